FILE: hdl/mm4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point matrix multiplier.
package mm4_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;

  // Default geometry and number format.
  localparam int DEF_DIM       = 4;
  localparam int DEF_FRAC_BITS = 16;

  // Saturation limits of a signed 32-bit result.
  localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_COMPUTE
  } state_t;

  // Position and end marker that travel with each result through the pipeline.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] index;
  } tag_t;

endpackage

FILE: hdl/matrix_multiply_4x4.sv
`timescale 1ns / 1ps
// Top level of the fixed-point DIM x DIM matrix multiplier.
//
// The block multiplies two square matrices held column-major in signed fixed
// point (Q16.16 by default). Each input transfer loads one left element and one
// right element at element_index = DIM*column + row. The transfer for the last
// position (15 for a 4x4 matrix) starts the product: input stall then stays
// high while the DIM*DIM results are issued, one per cycle as long as the
// output is not stalled, and results leave in position order with
// last_element set on the final one. The issue rate is set by the DIM
// parallel lanes: each lane owns one term of the dot product, holds its left
// column and right row in two small memories, and multiplies once per cycle
// while the pipeline advances; a registered adder tree of log2(DIM) levels
// merges the lanes. From issue, a result passes the read registers, the
// product register, the tree levels and the output register. A stall on the
// output freezes the whole pipeline. Each sum is arithmetically shifted right
// by FRAC_BITS and saturated to 32 bits. Element positions at or above
// DIM*DIM are ignored, and reading a position that was never loaded gives an
// unspecified value.
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int DIM       = DEF_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [ELEM_W-1:0] left_element,
  input  logic signed [ELEM_W-1:0] right_element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         product_index,
  output logic signed [ELEM_W-1:0] product_element,
  output logic                     last_element
);

  localparam int AW    = $clog2(DIM);
  localparam int DEPTH = 2 + $clog2(DIM);
  localparam int CELLS = DIM * DIM;
  localparam logic [6:0] CELLS_W7 = 7'(CELLS);
  localparam logic [6:0] LAST_W7  = 7'(CELLS - 1);

  state_t state;
  state_t state_next;

  logic          in_xfer;
  logic          wr_en;
  logic          start_load;
  logic [6:0]    idx7;
  logic [AW-1:0] wr_col;
  logic [AW-1:0] wr_row;

  logic             adv;
  logic             issue;
  logic             issue_last;
  logic [AW-1:0]    rd_row;
  logic [AW-1:0]    rd_col;
  logic [IDX_W-1:0] issue_idx;

  logic [DEPTH-1:0] vld;
  tag_t             tag [DEPTH];

  logic signed [PROD_W-1:0] lane_product [DIM];
  logic signed [ELEM_W-1:0] sat_value;

  // Input side: decode the column-major position into column and row.
  assign in_xfer    = in_valid && !in_stall;
  assign idx7       = 7'(element_index);
  assign wr_en      = in_xfer && (idx7 < CELLS_W7);
  assign start_load = wr_en && (idx7 == LAST_W7);

  always_comb begin
    wr_col = '0;
    for (int c = 1; c < DIM; c++) begin
      if (idx7 >= 7'(DIM * c)) begin
        wr_col = AW'(c);
      end
    end
    wr_row = AW'(idx7 - 7'(DIM) * 7'(wr_col));
  end

  // The whole pipeline moves whenever the output register can take a new value.
  assign adv        = !out_valid || !out_stall;
  assign issue_last = (rd_row == AW'(DIM - 1)) && (rd_col == AW'(DIM - 1));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_load) begin
          state_next = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        if (adv && issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        issue    = 1'b0;
        in_stall = 1'b0;
      end
      ST_COMPUTE: begin
        issue    = 1'b1;
        in_stall = 1'b1;
      end
      default: begin
        issue    = 1'b0;
        in_stall = 1'b1;
      end
    endcase
  end

  // Issue counters walk the product positions row first, then column.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row    <= '0;
      rd_col    <= '0;
      issue_idx <= '0;
    end else if (issue && adv) begin
      if (issue_last) begin
        rd_row    <= '0;
        rd_col    <= '0;
        issue_idx <= '0;
      end else if (rd_row == AW'(DIM - 1)) begin
        rd_row    <= '0;
        rd_col    <= rd_col + 1'b1;
        issue_idx <= issue_idx + 1'b1;
      end else begin
        rd_row    <= rd_row + 1'b1;
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  // Lane k holds left column k (addressed by row) and right row k (addressed by column).
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    mm4_lane #(
      .DIM(DIM)
    ) u_lane (
      .clk          (clk),
      .adv          (adv),
      .left_we      (wr_en && (wr_col == AW'(k))),
      .right_we     (wr_en && (wr_row == AW'(k))),
      .left_wr_addr (wr_row),
      .right_wr_addr(wr_col),
      .left_data    (left_element),
      .right_data   (right_element),
      .left_rd_addr (rd_row),
      .right_rd_addr(rd_col),
      .product      (lane_product[k])
    );
  end

  mm4_merge #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk      (clk),
    .adv      (adv),
    .products (lane_product),
    .sat_value(sat_value)
  );

  // Valid bits and tags follow the data: read, multiply, then the tree levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0].index <= issue_idx;
      tag[0].last  <= issue_last;
      for (int j = 1; j < DEPTH; j++) begin
        tag[j] <= tag[j-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      product_element <= sat_value;
      product_index   <= tag[DEPTH-1].index;
      last_element    <= tag[DEPTH-1].last;
    end
  end

`ifndef SYNTHESIS
  // Results leave in position order: the next one follows the previous, and a
  // new matrix starts again at position zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid ||
      (product_index == ($past(last_element) ? '0 : 4'($past(product_index) + 4'd1))))
    else $error("product positions out of order");

  // Computation only starts right after the last position was loaded.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMPUTE) && ($past(state) == ST_IDLE)) |-> $past(start_load))
    else $error("computation started without the last load");

  // A stalled result stays valid and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(product_index) &&
      $stable(product_element) && $stable(last_element))
    else $error("stalled result changed");
`endif

endmodule

FILE: hdl/mm4_lane.sv
`timescale 1ns / 1ps
// Multiply lane: holds a left column and right row, one product per cycle unless stalled.
module mm4_lane
  import mm4_pkg::*;
#(
  parameter int DIM = DEF_DIM
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic                     left_we,
  input  logic                     right_we,
  input  logic [$clog2(DIM)-1:0]   left_wr_addr,
  input  logic [$clog2(DIM)-1:0]   right_wr_addr,
  input  logic signed [ELEM_W-1:0] left_data,
  input  logic signed [ELEM_W-1:0] right_data,
  input  logic [$clog2(DIM)-1:0]   left_rd_addr,
  input  logic [$clog2(DIM)-1:0]   right_rd_addr,
  output logic signed [PROD_W-1:0] product
);

  logic signed [ELEM_W-1:0] left_mem [DIM];
  logic signed [ELEM_W-1:0] right_mem [DIM];
  logic signed [ELEM_W-1:0] left_q;
  logic signed [ELEM_W-1:0] right_q;

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_wr_addr] <= left_data;
    end
    if (right_we) begin
      right_mem[right_wr_addr] <= right_data;
    end
  end

  // Registered reads, then a registered product; both hold while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      left_q  <= left_mem[left_rd_addr];
      right_q <= right_mem[right_rd_addr];
      product <= PROD_W'(left_q) * PROD_W'(right_q);
    end
  end

endmodule

FILE: hdl/mm4_merge.sv
`timescale 1ns / 1ps
// Registered adder tree over the lane products, followed by shift and saturation.
module mm4_merge
  import mm4_pkg::*;
#(
  parameter int DIM       = DEF_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [PROD_W-1:0] products [DIM],
  output logic signed [ELEM_W-1:0] sat_value
);

  localparam int LEVELS = $clog2(DIM);
  localparam int PAD    = 1 << LEVELS;
  localparam int SUM_W  = PROD_W + LEVELS;
  localparam int UP_W   = SUM_W - ELEM_W + 1;

  logic signed [SUM_W-1:0] leaf [PAD];
  logic signed [SUM_W-1:0] node [1:PAD-1];
  logic signed [SUM_W-1:0] shifted;
  logic [UP_W-1:0]         upper;
  logic                    fits;

  // Leaves beyond the matrix size are zero so the tree stays balanced.
  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < DIM) begin : g_used
      assign leaf[i] = SUM_W'(products[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap-ordered tree: node i sums nodes 2i and 2i+1; every path has LEVELS registers.
  for (genvar i = 1; i < PAD; i++) begin : g_node
    if (2 * i >= PAD) begin : g_bottom
      always_ff @(posedge clk) begin
        if (adv) begin
          node[i] <= leaf[2*i-PAD] + leaf[2*i+1-PAD];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (adv) begin
          node[i] <= node[2*i] + node[2*i+1];
        end
      end
    end
  end

  // Arithmetic shift rounds toward minus infinity; saturate when the upper bits
  // are not a plain sign extension.
  always_comb begin
    shifted = node[1] >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:ELEM_W-1];
    fits    = (&upper) || !(|upper);
    if (fits) begin
      sat_value = shifted[ELEM_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      sat_value = SAT_MIN;
    end else begin
      sat_value = SAT_MAX;
    end
  end

endmodule

FILE: tb/sv/matrix_multiply_4x4_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-point 4x4 matrix multiplier.
module matrix_multiply_4x4_tb;
  import mm4_pkg::*;

  localparam int CELLS      = DEF_DIM * DEF_DIM;
  localparam int LAST_POS   = CELLS - 1;
  localparam int LOAD_ITEMS = 430;
  // Tail wait after the last owed product; it leaves ample room.
  localparam int DRAIN_CYCLES = 40;
  // The timeout lies well beyond the run time even if every load started a full
  // product and every result met the longest output stall.
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  // One product element as the block should deliver it.
  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [ELEM_W-1:0] element;
    logic                     last;
  } product_t;

  // Keeps a private copy of both operand matrices and the products still owed.
  class product_scoreboard;
    logic signed [ELEM_W-1:0] left_mem [CELLS];
    logic signed [ELEM_W-1:0] right_mem [CELLS];
    product_t awaited [$];
    int errors = 0;

    // Exact dot product, floor shift by the fraction width, then clamp to 32 bits.
    function logic signed [ELEM_W-1:0] dot_product(int row, int col);
      logic signed [65:0] acc;
      logic signed [65:0] lhs;
      logic signed [65:0] rhs;
      acc = '0;
      for (int k = 0; k < DEF_DIM; k++) begin
        lhs = left_mem[DEF_DIM * k + row];
        rhs = right_mem[DEF_DIM * col + k];
        acc = acc + lhs * rhs;
      end
      acc = acc >>> DEF_FRAC_BITS;
      if (acc > 66'sd2147483647) return SAT_MAX;
      if (acc < -66'sd2147483648) return SAT_MIN;
      return acc[ELEM_W-1:0];
    endfunction

    // Stores one load transfer; the last position queues the whole product.
    function void note_load(logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] lval,
                            logic signed [ELEM_W-1:0] rval);
      product_t p;
      left_mem[idx]  = lval;
      right_mem[idx] = rval;
      if (idx == LAST_POS) begin
        for (int k = 0; k < CELLS; k++) begin
          p.index   = IDX_W'(k);
          p.element = dot_product(k % DEF_DIM, k / DEF_DIM);
          p.last    = (k == LAST_POS);
          awaited.push_back(p);
        end
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] elem,
                               logic lst);
      product_t p;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected product, index %0d element %h", $time, idx, elem);
        errors++;
        return;
      end
      p = awaited.pop_front();
      if (idx !== p.index) begin
        $display("%0t: product_index expected %0d, got %0d", $time, p.index, idx);
        errors++;
      end
      if (elem !== p.element) begin
        $display("%0t: product_element at %0d expected %h, got %h",
                 $time, p.index, p.element, elem);
        errors++;
      end
      if (lst !== p.last) begin
        $display("%0t: last_element at %0d expected %b, got %b",
                 $time, p.index, p.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [IDX_W-1:0]         element_index;
  logic signed [ELEM_W-1:0] left_element;
  logic signed [ELEM_W-1:0] right_element;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         product_index;
  logic signed [ELEM_W-1:0] product_element;
  logic                     last_element;

  product_scoreboard sb;
  int loads_sent;
  // When set, the sender runs back to back with no idle cycles.
  bit sender_burst;

  matrix_multiply_4x4 u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .element_index   (element_index),
    .left_element    (left_element),
    .right_element   (right_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .product_index   (product_index),
    .product_element (product_element),
    .last_element    (last_element)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Operand values: a mix of Q16.16 numbers in [-8, 8), raw random words and extremes.
  function automatic logic signed [ELEM_W-1:0] pick_operand();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = SAT_MAX;
          1: v = SAT_MIN;
          2: v = '0;
          3: v = '1;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  // Drives one load transfer after a random idle gap and waits until it is taken.
  // Valid stays high afterward so that back-to-back transfers need no extra edge.
  task automatic send_load(input logic [IDX_W-1:0] idx, input logic signed [ELEM_W-1:0] lval,
                           input logic signed [ELEM_W-1:0] rval);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_index <= idx;
    left_element  <= lval;
    right_element <= rval;
    do @(posedge clk); while (in_stall);
    sb.note_load(idx, lval, rval);
    loads_sent++;
  endtask

  // Holds the input side quiet until every owed product has come out.
  task automatic wait_all_products();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Output side: stall in runs of random length, with long stretches of no stall.
  initial begin : result_monitor
    int run_left;
    bit stall_run;
    run_left  = 0;
    stall_run = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(product_index, product_element, last_element);
      if (run_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          stall_run = 1'b0;
          run_left  = $urandom_range(40, 150);
        end else begin
          stall_run = ($urandom_range(0, 2) == 0);
          run_left  = stall_run ? pick_gap() + 1 : $urandom_range(1, 6);
        end
      end
      run_left--;
      out_stall <= stall_run;
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL matrix_multiply_4x4");
    $finish;
  end

  initial begin : stimulus
    logic signed [ELEM_W-1:0] corner_vals [CELLS];
    logic [IDX_W-1:0] order [CELLS-1];
    logic [IDX_W-1:0] tmp;
    int kind;
    int count;
    int seq;
    int j;

    sb            = new;
    loads_sent    = 0;
    sender_burst  = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    element_index = '0;
    left_element  = '0;
    right_element = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // First load writes every position in order, so no later product ever reads
    // an entry that was never written. The corner values include both 32-bit
    // extremes, zero, minus one and small fractions that round toward minus
    // infinity. The square of the most negative value drives the first product
    // element into positive saturation.
    corner_vals = '{SAT_MIN, SAT_MAX, 32'sd0, -32'sd1, 32'sh0001_0000, 32'sd1,
                    -32'sh0001_0000, 32'sd2, 32'sh7FFF_0000, 32'sh0000_8000,
                    -32'sh0000_8000, 32'sh0001_8000, 32'shFFFE_8000, 32'sd3,
                    -32'sd2, SAT_MAX};
    for (int i = 0; i < CELLS; i++)
      send_load(IDX_W'(i), corner_vals[i], corner_vals[i]);

    // Partial reload: row 0 of the left matrix at the top and column 0 of the
    // right matrix at the bottom, so the first product element saturates low.
    foreach (order[i]) order[i] = '0;
    order[0] = IDX_W'(0); order[1] = IDX_W'(1); order[2] = IDX_W'(2);
    order[3] = IDX_W'(3); order[4] = IDX_W'(4); order[5] = IDX_W'(8);
    order[6] = IDX_W'(12);
    for (int i = 0; i < 7; i++)
      send_load(order[i], SAT_MAX, SAT_MIN);
    send_load(IDX_W'(LAST_POS), SAT_MIN, SAT_MAX);

    // Random part. Most sequences load every position in shuffled order and
    // finish on the last position; the rest are short reloads that still start
    // a product, or stray writes that start nothing.
    seq = 0;
    while (loads_sent < LOAD_ITEMS) begin
      sender_burst = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        for (int i = 0; i < CELLS - 1; i++) order[i] = IDX_W'(i);
        for (int i = CELLS - 2; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < CELLS - 1; i++)
          send_load(order[i], pick_operand(), pick_operand());
        send_load(IDX_W'(LAST_POS), pick_operand(), pick_operand());
      end else begin
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
          send_load(IDX_W'($urandom_range(0, LAST_POS - 1)), pick_operand(), pick_operand());
        if (kind < 9)
          send_load(IDX_W'(LAST_POS), pick_operand(), pick_operand());
      end
      // Now and then let the block drain completely before the next sequence.
      if (seq == 2 || $urandom_range(0, 7) == 0)
        wait_all_products();
      seq++;
    end

    sender_burst = 1'b0;
    if (in_valid)
      in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS matrix_multiply_4x4");
    else
      $display("FAIL matrix_multiply_4x4");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mm4_pkg.sv
hdl/mm4_lane.sv
hdl/mm4_merge.sv
hdl/matrix_multiply_4x4.sv
tb/sv/matrix_multiply_4x4_tb.sv
